### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the dual stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SADSTK_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("sadstk assertion failed");
`define SADSTK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sadstk assertion failed");
`else
`define SADSTK_ASSERT(label, expr)
`define SADSTK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/sadstk_pkg.sv
// Types and codes shared by the dual stack modules.
`default_nettype none

package sadstk_pkg;

    localparam logic [2:0] OP_QUERY      = 3'd0;
    localparam logic [2:0] OP_PUSH_LEFT  = 3'd1;
    localparam logic [2:0] OP_PUSH_RIGHT = 3'd2;
    localparam logic [2:0] OP_POP_LEFT   = 3'd3;
    localparam logic [2:0] OP_POP_RIGHT  = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] push_value;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] left_top;
        logic        left_valid;
        logic [31:0] right_top;
        logic        right_valid;
        logic [4:0]  length;
    } t_result;

    typedef struct packed {
        logic [1:0] status;
        logic       left_valid;
        logic       right_valid;
        logic [4:0] length;
        logic       wr_en;
    } t_cmd_flags;

endpackage

`default_nettype wire

### rtl/sadstk_front.sv
// Front end: tracks both stack heights and turns each item into a store command.
`default_nettype none

module sadstk_front #(
    parameter int CAPACITY = 16,
    parameter int AW = 4,
    parameter int HW = 5,
    parameter int DW = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  sadstk_pkg::t_item     i_item,
    output sadstk_pkg::t_cmd_flags o_flags,
    output logic [AW-1:0]         o_wr_addr,
    output logic [AW-1:0]         o_left_addr,
    output logic [AW-1:0]         o_right_addr,
    output logic [DW-1:0]         o_wr_data
);
    import sadstk_pkg::*;

    localparam int SW = (HW > 5) ? HW : 5;

    logic [HW-1:0] r_lh;
    logic [HW-1:0] r_rh;
    logic [HW-1:0] n_lh;
    logic [HW-1:0] n_rh;
    logic [HW-1:0] w_total;
    logic          w_full;
    logic [HW-1:0] w_rslot;
    logic [HW-1:0] w_lidx;
    logic [HW-1:0] w_ridx;
    logic [SW-1:0] w_len;
    logic [1:0]    w_status;
    logic          w_we;
    logic [AW-1:0] w_waddr;

    assign w_total = r_lh + r_rh;
    assign w_full  = (w_total >= HW'(CAPACITY));
    assign w_rslot = HW'(CAPACITY) - r_rh - HW'(1);

    always_comb begin
        n_lh     = r_lh;
        n_rh     = r_rh;
        w_status = ST_DONE;
        w_we     = 1'b0;
        w_waddr  = r_lh[AW-1:0];
        unique case (i_item.op)
            OP_PUSH_LEFT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_lh[AW-1:0];
                    n_lh    = r_lh + HW'(1);
                end
            end
            OP_PUSH_RIGHT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_rslot[AW-1:0];
                    n_rh    = r_rh + HW'(1);
                end
            end
            OP_POP_LEFT: begin
                if (r_lh == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_lh = r_lh - HW'(1);
                end
            end
            OP_POP_RIGHT: begin
                if (r_rh == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_rh = r_rh - HW'(1);
                end
            end
            OP_CLEAR: begin
                n_lh = '0;
                n_rh = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_lidx = n_lh - HW'(1);
    assign w_ridx = HW'(CAPACITY) - n_rh;
    assign w_len  = SW'(n_lh) + SW'(n_rh);

    assign o_flags.status      = w_status;
    assign o_flags.left_valid  = (n_lh != '0);
    assign o_flags.right_valid = (n_rh != '0);
    assign o_flags.length      = w_len[4:0];
    assign o_flags.wr_en       = w_we;
    assign o_wr_addr           = w_waddr;
    assign o_left_addr         = w_lidx[AW-1:0];
    assign o_right_addr        = w_ridx[AW-1:0];
    assign o_wr_data           = i_item.push_value[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lh <= '0;
            r_rh <= '0;
        end else if (i_accept) begin
            r_lh <= n_lh;
            r_rh <= n_rh;
        end
    end

endmodule

`default_nettype wire

### rtl/sadstk_queue.sv
// Two-entry command queue between the front end and the store.
`default_nettype none

module sadstk_queue #(
    parameter int W = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_wr,
    input  wire [W-1:0]  i_data,
    input  wire          i_rd,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    logic [W-1:0] r_slot [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_count;

    assign o_data  = r_slot[r_rp];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

endmodule

`default_nettype wire

### rtl/sadstk_back.sv
// Back end: word store with one write and two registered reads, plus the result register.
`default_nettype none

module sadstk_back #(
    parameter int CAPACITY = 16,
    parameter int AW = 4,
    parameter int DW = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cmd_empty,
    input  sadstk_pkg::t_cmd_flags i_flags,
    input  wire [AW-1:0]           i_wr_addr,
    input  wire [AW-1:0]           i_left_addr,
    input  wire [AW-1:0]           i_right_addr,
    input  wire [DW-1:0]           i_wr_data,
    output logic                   o_cmd_pop,
    input  wire                    i_pop,
    output logic                   o_empty,
    output sadstk_pkg::t_result    o_result
);
    import sadstk_pkg::*;

    logic [DW-1:0] r_mem [CAPACITY];
    logic [DW-1:0] r_ltop;
    logic [DW-1:0] r_rtop;
    t_cmd_flags    r_flags;
    logic          r_valid;
    logic          w_fire;

    assign w_fire    = !i_cmd_empty && (!r_valid || i_pop);
    assign o_cmd_pop = w_fire;
    assign o_empty   = !r_valid;

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (i_flags.wr_en) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
            if (i_flags.wr_en && (i_wr_addr == i_left_addr)) begin
                r_ltop <= i_wr_data;
            end else begin
                r_ltop <= r_mem[i_left_addr];
            end
            if (i_flags.wr_en && (i_wr_addr == i_right_addr)) begin
                r_rtop <= i_wr_data;
            end else begin
                r_rtop <= r_mem[i_right_addr];
            end
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_result.status      = r_flags.status;
    assign o_result.left_top    = r_flags.left_valid ? 32'(r_ltop) : 32'd0;
    assign o_result.left_valid  = r_flags.left_valid;
    assign o_result.right_top   = r_flags.right_valid ? 32'(r_rtop) : 32'd0;
    assign o_result.right_valid = r_flags.right_valid;
    assign o_result.length      = r_flags.length;

endmodule

`default_nettype wire

### rtl/shared_array_dual_stack.sv
// Top level of the dual stack block: two stacks sharing one word store.
//
// Two stacks share one store of CAPACITY words, the left one growing up from
// entry 0 and the right one growing down from the top entry. Every item
// carries one operation and yields exactly one result that describes both
// stacks after it. The block takes one item per clock cycle when neither side
// stalls. The command of an accepted item is written into the queue, and it
// leaves the queue when the store is read into the result register, once the
// result register is empty or its result is taken. While a result waits to be
// taken, up to two more commands wait in the queue, and then full rises. A
// push into a full store is refused and a pop from an empty side is ignored,
// each with its own status.
// Only the low WORD_WIDTH bits of a pushed word are kept, up to 32 bits.
`default_nettype none
`include "assert_macros.svh"

module shared_array_dual_stack #(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  sadstk_pkg::t_item    i_item,
    output logic                 empty,
    input  wire                  pop,
    output sadstk_pkg::t_result  o_result
);
    import sadstk_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int HW = $clog2(CAPACITY + 1);
    localparam int DW = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;
    localparam int FW = $bits(t_cmd_flags);
    localparam int QW = FW + 3 * AW + DW;

    logic          w_accept;
    t_cmd_flags    w_flags;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_left_addr;
    logic [AW-1:0] w_right_addr;
    logic [DW-1:0] w_wr_data;
    logic [QW-1:0] w_q_in;
    logic [QW-1:0] w_q_out;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_q_pop;
    t_cmd_flags    w_b_flags;
    logic [AW-1:0] w_b_wr_addr;
    logic [AW-1:0] w_b_left_addr;
    logic [AW-1:0] w_b_right_addr;
    logic [DW-1:0] w_b_wr_data;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    sadstk_front #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .HW       (HW),
        .DW       (DW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_item       (i_item),
        .o_flags      (w_flags),
        .o_wr_addr    (w_wr_addr),
        .o_left_addr  (w_left_addr),
        .o_right_addr (w_right_addr),
        .o_wr_data    (w_wr_data)
    );

    assign w_q_in = {w_flags, w_wr_addr, w_left_addr, w_right_addr, w_wr_data};

    sadstk_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_data  (w_q_in),
        .i_rd    (w_q_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    assign {w_b_flags, w_b_wr_addr, w_b_left_addr, w_b_right_addr, w_b_wr_data} = w_q_out;

    sadstk_back #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .DW       (DW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (w_q_empty),
        .i_flags      (w_b_flags),
        .i_wr_addr    (w_b_wr_addr),
        .i_left_addr  (w_b_left_addr),
        .i_right_addr (w_b_right_addr),
        .i_wr_data    (w_b_wr_data),
        .o_cmd_pop    (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

    `SADSTK_ASSERT(a_write_only_when_done, !w_flags.wr_en || (w_flags.status == ST_DONE))
    `SADSTK_ASSERT_NEXT(a_no_result_from_nothing, w_q_empty && empty && !w_accept, empty)
    `SADSTK_ASSERT(a_empty_left_reads_zero, empty || o_result.left_valid || (o_result.left_top == 32'd0))
    `SADSTK_ASSERT(a_empty_right_reads_zero, empty || o_result.right_valid || (o_result.right_top == 32'd0))

endmodule

`default_nettype wire

### sim/sadstk_checker.sv
// Checker for the dual stack block: predicts each result and compares it with the block's output.
module sadstk_checker
    import sadstk_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     push,
    input  wire     full,
    input  t_item   i_item,
    input  wire     empty,
    input  wire     pop,
    input  t_result o_result,
    output int      o_mismatches,
    output int      o_pending
);

    localparam logic [31:0] WORD_MASK =
        (WORD_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WORD_WIDTH) - 32'd1);

    logic [31:0] word_store [CAPACITY];
    int unsigned left_height = 0;
    int unsigned right_height = 0;
    t_result     awaited_results [$];
    int          mismatch_count = 0;

    function automatic t_result predict_result(input t_item it);
        t_result     r;
        logic [31:0] word;
        logic        store_full;
        word = it.push_value & WORD_MASK;
        r = '0;
        r.status = ST_DONE;
        store_full = (left_height + right_height) >= CAPACITY;
        case (it.op)
            OP_PUSH_LEFT: begin
                if (store_full) begin
                    r.status = ST_FULL;
                end else begin
                    word_store[left_height] = word;
                    left_height++;
                end
            end
            OP_PUSH_RIGHT: begin
                if (store_full) begin
                    r.status = ST_FULL;
                end else begin
                    right_height++;
                    word_store[CAPACITY - right_height] = word;
                end
            end
            OP_POP_LEFT: begin
                if (left_height == 0) r.status = ST_EMPTY;
                else left_height--;
            end
            OP_POP_RIGHT: begin
                if (right_height == 0) r.status = ST_EMPTY;
                else right_height--;
            end
            OP_CLEAR: begin
                left_height = 0;
                right_height = 0;
            end
            default: begin
            end
        endcase
        r.left_valid = (left_height != 0);
        r.right_valid = (right_height != 0);
        if (r.left_valid) r.left_top = word_store[left_height - 1];
        if (r.right_valid) r.right_top = word_store[CAPACITY - right_height];
        r.length = 5'(left_height + right_height);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %0d: %s expected %h, got %h", mismatch_count, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            awaited_results.delete();
            left_height = 0;
            right_height = 0;
        end else begin
            if (pop && !empty) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch %0d: result %h arrived with no item waiting",
                                 mismatch_count, o_result);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(o_result.status));
                    if (o_result.left_top !== want.left_top)
                        note_mismatch("left_top", want.left_top, o_result.left_top);
                    if (o_result.left_valid !== want.left_valid)
                        note_mismatch("left_valid", 32'(want.left_valid),
                                      32'(o_result.left_valid));
                    if (o_result.right_top !== want.right_top)
                        note_mismatch("right_top", want.right_top, o_result.right_top);
                    if (o_result.right_valid !== want.right_valid)
                        note_mismatch("right_valid", 32'(want.right_valid),
                                      32'(o_result.right_valid));
                    if (o_result.length !== want.length)
                        note_mismatch("length", 32'(want.length), 32'(o_result.length));
                end
            end
            if (push && !full) awaited_results.push_back(predict_result(i_item));
        end
        o_pending <= awaited_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

### sim/tb_top.sv
// Testbench top for the dual stack block: clock, reset, item stimulus and the final verdict.
module tb_top;
    import sadstk_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;
    localparam int ITEM_COUNT = 1900;

    localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    t_item   i_item = '0;
    logic    full;
    logic    empty;
    t_result o_result;
    int      mismatches;
    int      pending;
    int      items_sent = 0;

    always #6 i_clk = ~i_clk;

    shared_array_dual_stack #(
        .CAPACITY(CAPACITY),
        .WORD_WIDTH(WORD_WIDTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_item(i_item),
        .empty(empty),
        .pop(pop),
        .o_result(o_result)
    );

    sadstk_checker #(
        .CAPACITY(CAPACITY),
        .WORD_WIDTH(WORD_WIDTH)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_item(i_item),
        .empty(empty),
        .pop(pop),
        .o_result(o_result),
        .o_mismatches(mismatches),
        .o_pending(pending)
    );

    task automatic send_item(input logic [2:0] op_code, input logic [31:0] word);
        if ((items_sent < 700 || items_sent >= 1000) && $urandom_range(99) < 18) begin
            push <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 18) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= '{op: op_code, push_value: word};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    initial begin
        int episode;
        int count;
        int roll;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_QUERY, 32'h0000_0000);
        send_item(OP_POP_LEFT, 32'hFFFF_FFFF);
        send_item(OP_POP_RIGHT, 32'hFFFF_FFFF);
        send_item(OP_PUSH_LEFT, 32'h0000_0000);
        send_item(OP_PUSH_LEFT, 32'hFFFF_FFFF);
        send_item(OP_PUSH_RIGHT, 32'hFFFF_FFFF);
        send_item(OP_PUSH_RIGHT, 32'h0000_0000);
        send_item(OP_PUSH_RIGHT, 32'hA5A5_5A5A);
        send_item(OP_QUERY, 32'hFFFF_FFFF);
        send_item(OP_SPARE_LOW, 32'h1234_5678);
        send_item(OP_SPARE_HIGH, 32'h8765_4321);
        send_item(OP_POP_LEFT, 32'h0000_0000);
        send_item(OP_POP_RIGHT, 32'h0000_0000);
        send_item(OP_POP_RIGHT, 32'h0000_0000);
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 32'h0000_0000);
        send_item(OP_POP_LEFT, 32'h0000_0000);

        while (items_sent < ITEM_COUNT) begin
            episode = $urandom_range(9);
            if (episode < 3) begin
                // Fill the store from a clean start and run into refused pushes.
                send_item(OP_CLEAR, $urandom);
                count = $urandom_range(CAPACITY + 4, CAPACITY + 1);
                repeat (count) begin
                    send_item($urandom_range(1) ? OP_PUSH_LEFT : OP_PUSH_RIGHT, $urandom);
                end
            end else if (episode < 5) begin
                count = $urandom_range(CAPACITY + 4, CAPACITY / 2);
                repeat (count) begin
                    send_item($urandom_range(1) ? OP_POP_LEFT : OP_POP_RIGHT, $urandom);
                end
            end else if (episode < 9) begin
                repeat (20) begin
                    roll = $urandom_range(99);
                    if (roll < 30) send_item(OP_PUSH_LEFT, $urandom);
                    else if (roll < 60) send_item(OP_PUSH_RIGHT, $urandom);
                    else if (roll < 75) send_item(OP_POP_LEFT, $urandom);
                    else if (roll < 90) send_item(OP_POP_RIGHT, $urandom);
                    else if (roll < 93) send_item(OP_CLEAR, $urandom);
                    else if (roll < 97) send_item(OP_QUERY, $urandom);
                    else send_item($urandom_range(1) ? OP_SPARE_LOW : OP_SPARE_HIGH, $urandom);
                end
            end else begin
                repeat (5) send_item(3'($urandom_range(7)), $urandom);
            end
        end
        push <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        int cycle;
        int hold_left;
        cycle = 0;
        hold_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cycle++;
            // The receiver holds off long enough for the block to fill and stall its input.
            if (cycle == 150 || cycle == 1500) hold_left = 90;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (cycle >= 800 && cycle < 1100) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 18);
            end
        end
    end

    initial begin
        #(12 * 200000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
